@@ rtl/waltt_pkg.sv @@
// Shared types, codes and sizes of the write-ahead log transaction tracker.
package waltt_pkg;

    // Table sizing
    localparam int LOG_ENTRIES   = 32;
    localparam int MAX_OP_BLOCKS = 10;
    localparam int IDX_W         = $clog2(LOG_ENTRIES);
    localparam int COUNT_W       = $clog2(LOG_ENTRIES + 1);
    localparam int OPEN_W        = 6;
    localparam int NEED_W        = COUNT_W + OPEN_W + 6;

    // Field widths
    localparam int BLOCK_W  = 32;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 4;
    localparam int REQ_W    = 2;
    localparam int CFG_W    = 11;
    localparam int OUT_W    = 40;

    localparam logic [CFG_W-1:0] LOG_AREA_RESET = 11'd33;

    // Request kinds as carried in the input tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_BEGIN = 2'd0,
        REQ_END   = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_DONE  = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ADMITTED       = 4'd0,
        ST_WAIT           = 4'd1,
        ST_ENDED          = 4'd2,
        ST_COMMIT         = 4'd3,
        ST_ABSORBED       = 4'd4,
        ST_APPENDED       = 4'd5,
        ST_CLEARED        = 4'd6,
        ST_ERR_FULL       = 4'd7,
        ST_ERR_NO_OP      = 4'd8,
        ST_ERR_END_IDLE   = 4'd9,
        ST_ERR_END_COMMIT = 4'd10,
        ST_ERR_DONE_IDLE  = 4'd11
    } status_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_SEARCH = 2'd1,
        BK_COMMIT = 2'd2
    } back_state_t;

    // Classified request handed from front to back
    typedef struct packed {
        req_t               req;
        logic [BLOCK_W-1:0] blk;
    } item_t;

endpackage

@@ rtl/waltt_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
module waltt_front
    import waltt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [REQ_W-1:0]   s_tuser,   // req_type
    input  logic [BLOCK_W-1:0] s_tdata,   // block_number
    output logic               item_valid,
    input  logic               item_ready,
    output item_t              item
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    item_t             queue_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              push, pop;
    item_t             in_item;

    // Classify the incoming transaction
    always_comb
    begin
        in_item.req = req_t'(s_tuser);
        in_item.blk = s_tdata;
    end

    assign s_tready   = (fill_reg != FILL_W'(DEPTH));
    assign item_valid = (fill_reg != '0);
    assign item       = queue_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_valid && item_ready;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = FILL_W'(fill_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            fill_next = FILL_W'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold queued transactions
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/waltt_back.sv @@
// Back end: log table, operation bookkeeping, search and commit sequencing.
module waltt_back
    import waltt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  item_t               item,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [STATUS_W-1:0] m_tuser,
    output logic [OUT_W-1:0]    m_tdata,
    output logic                m_tlast
);

    back_state_t          state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [OPEN_W-1:0]    open_reg, open_next;
    logic                 commit_reg, commit_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [BLOCK_W-1:0]   blk_reg, blk_next;
    logic [CFG_W-1:0]     log_area_reg;

    logic [BLOCK_W-1:0]   mem [LOG_ENTRIES];
    logic [BLOCK_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;

    logic                 m_valid_reg, m_valid_next;
    status_t              out_status_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [BLOCK_W-1:0]   out_entry_reg;
    logic                 out_pin_reg;
    logic                 out_last_reg;

    logic                 emit;
    status_t              e_status;
    logic [SLOT_W-1:0]    e_slot;
    logic [BLOCK_W-1:0]   e_entry;
    logic                 e_pin;
    logic                 e_last;

    logic                 out_free;
    logic                 pop;
    logic [NEED_W-1:0]    need;
    logic                 begin_ok;
    logic                 log_full;
    logic                 at_end;
    logic                 last_close;

    // Admission and capacity checks
    always_comb
    begin
        need = NEED_W'(count_reg)
             + (NEED_W'(open_reg) + NEED_W'(1)) * NEED_W'(MAX_OP_BLOCKS);
        begin_ok = !commit_reg && (need <= NEED_W'(LOG_ENTRIES));
        log_full = (count_reg >= COUNT_W'(LOG_ENTRIES))
                || ((12'(count_reg) + 12'd1) >= {1'b0, log_area_reg});
        at_end     = ((COUNT_W'(idx_reg) + COUNT_W'(1)) == count_reg);
        last_close = (open_reg == OPEN_W'(1)) && (count_reg != '0);
    end

    assign out_free   = !m_valid_reg || m_tready;
    assign pop        = (state_reg == BK_IDLE) && item_valid && out_free;
    assign item_ready = pop;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop)
                begin
                    if ((item.req == REQ_END) && !commit_reg && last_close)
                    begin
                        state_next = BK_COMMIT;
                    end
                    else if ((item.req == REQ_WRITE) && !log_full
                             && (open_reg != '0) && (count_reg != '0))
                    begin
                        state_next = BK_SEARCH;
                    end
                end
            end
            BK_SEARCH:
            begin
                if (out_free && ((rd_data_reg == blk_reg) || at_end))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_COMMIT:
            begin
                if (out_free && at_end)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and results
    always_comb
    begin
        count_next  = count_reg;
        open_next   = open_reg;
        commit_next = commit_reg;
        idx_next    = idx_reg;
        blk_next    = blk_reg;
        rd_addr     = idx_reg;
        mem_we      = 1'b0;
        emit        = 1'b0;
        e_status    = ST_ADMITTED;
        e_slot      = '0;
        e_entry     = '0;
        e_pin       = 1'b0;
        e_last      = 1'b1;

        unique case (state_reg)
            BK_IDLE:
            begin
                idx_next = '0;
                rd_addr  = '0;
                blk_next = item.blk;
                if (pop)
                begin
                    unique case (item.req)
                        REQ_BEGIN:
                        begin
                            emit = 1'b1;
                            if (begin_ok)
                            begin
                                open_next = OPEN_W'(open_reg + 1'b1);
                                e_status  = ST_ADMITTED;
                            end
                            else
                            begin
                                e_status = ST_WAIT;
                            end
                        end
                        REQ_END:
                        begin
                            if (commit_reg)
                            begin
                                emit     = 1'b1;
                                e_status = ST_ERR_END_COMMIT;
                            end
                            else if (open_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_status = ST_ERR_END_IDLE;
                            end
                            else
                            begin
                                open_next = OPEN_W'(open_reg - 1'b1);
                                if (last_close)
                                begin
                                    commit_next = 1'b1;
                                end
                                else
                                begin
                                    emit     = 1'b1;
                                    e_status = ST_ENDED;
                                end
                            end
                        end
                        REQ_WRITE:
                        begin
                            if (log_full)
                            begin
                                emit     = 1'b1;
                                e_status = ST_ERR_FULL;
                            end
                            else if (open_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_status = ST_ERR_NO_OP;
                            end
                            else if (count_reg == '0)
                            begin
                                // Empty table: append straight into slot zero
                                mem_we     = 1'b1;
                                count_next = COUNT_W'(1);
                                emit       = 1'b1;
                                e_status   = ST_APPENDED;
                                e_entry    = item.blk;
                                e_pin      = 1'b1;
                            end
                        end
                        REQ_DONE:
                        begin
                            emit = 1'b1;
                            if (commit_reg)
                            begin
                                count_next  = '0;
                                commit_next = 1'b0;
                                e_status    = ST_CLEARED;
                            end
                            else
                            begin
                                e_status = ST_ERR_DONE_IDLE;
                            end
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            BK_SEARCH:
            begin
                if (out_free)
                begin
                    if (rd_data_reg == blk_reg)
                    begin
                        emit     = 1'b1;
                        e_status = ST_ABSORBED;
                        e_slot   = SLOT_W'(idx_reg);
                        e_entry  = blk_reg;
                    end
                    else if (at_end)
                    begin
                        // No match: append behind the last entry
                        mem_we     = 1'b1;
                        count_next = COUNT_W'(count_reg + 1'b1);
                        emit       = 1'b1;
                        e_status   = ST_APPENDED;
                        e_slot     = SLOT_W'(count_reg);
                        e_entry    = blk_reg;
                        e_pin      = 1'b1;
                    end
                    else
                    begin
                        idx_next = IDX_W'(idx_reg + 1'b1);
                        rd_addr  = IDX_W'(idx_reg + 1'b1);
                    end
                end
            end
            BK_COMMIT:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    e_status = ST_COMMIT;
                    e_slot   = SLOT_W'(idx_reg);
                    e_entry  = rd_data_reg;
                    e_last   = at_end;
                    if (!at_end)
                    begin
                        idx_next = IDX_W'(idx_reg + 1'b1);
                        rd_addr  = IDX_W'(idx_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        m_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            count_reg    <= '0;
            open_reg     <= '0;
            commit_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            log_area_reg <= LOG_AREA_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            open_reg    <= open_next;
            commit_reg  <= commit_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid)
            begin
                log_area_reg <= cfg_data;
            end
        end
    end

    // Working registers and output payload
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        blk_reg <= blk_next;
        if (emit)
        begin
            out_status_reg <= e_status;
            out_slot_reg   <= e_slot;
            out_entry_reg  <= e_entry;
            out_pin_reg    <= e_pin;
            out_last_reg   <= e_last;
        end
    end

    // Log table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[IDX_W'(count_reg)] <= blk_next;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_pin_reg, out_entry_reg, out_slot_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/write_ahead_log_transaction_tracker_top.sv @@
// Top level of the write-ahead log transaction tracker.
// Requests enter through a two-deep queue and are carried out one at a time by a
// sequencer that owns the log table. A write that reaches the table search walks
// the logged slots and ends early at the first matching slot, and a last close
// with a non-empty table reads out every logged entry. Both walks step one table
// slot a cycle through the table's single registered read port of the 32-entry
// table while the output is not stalled. A stalled output holds the sequencer.
module write_ahead_log_transaction_tracker_top
    import waltt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data,    // log_area_blocks
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [REQ_W-1:0]    s_tuser,     // req_type
    input  logic [BLOCK_W-1:0]  s_tdata,     // block_number
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [STATUS_W-1:0] m_tuser,     // status
    output logic [OUT_W-1:0]    m_tdata,     // slot_index, entry_block, pin_block, zero pad
    output logic                m_tlast      // last
);

    logic  item_valid;
    logic  item_ready;
    item_t item;

    assign cfg_ready = 1'b1;

    // Accept and queue requests
    waltt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // Carry out requests against the log table
    waltt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // Only a commit run has results that are not the last of their request
    a_last_single : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_COMMIT)) |-> m_tlast)
        else $error("non-commit result without last");

    // Pin only on an appended entry
    a_pin_append : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[37]) |-> (m_tuser == ST_APPENDED))
        else $error("pin on a result that is not an append");

    // Slot and block are zero unless the result names a table entry
    a_zero_payload : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_COMMIT) && (m_tuser != ST_ABSORBED)
         && (m_tuser != ST_APPENDED)) |-> (m_tdata[36:0] == '0))
        else $error("entry fields set on a result without an entry");

    // A request is taken from the queue only while the output can accept it
    a_pop_gated : assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |-> (!m_tvalid || m_tready))
        else $error("request taken while the result register is blocked");

endmodule

@@ dv/tb_write_ahead_log_transaction_tracker_top.sv @@
// Self-checking testbench for the write-ahead log transaction tracker top level.
`timescale 1ns / 1ps

module tb_write_ahead_log_transaction_tracker_top;
    import waltt_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_TICKS = 40;
    localparam int MAX_IDLE     = 17;

    // One expected response of the tracker
    typedef struct {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [BLOCK_W-1:0] blk;
        logic               pin;
        logic               last;
    } journal_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;       // log_area_blocks
    logic                s_tvalid;
    logic                s_tready;
    logic [REQ_W-1:0]    s_tuser;        // req_type
    logic [BLOCK_W-1:0]  s_tdata;        // block_number
    logic                m_tvalid;
    logic                m_tready;
    logic [STATUS_W-1:0] m_tuser;        // status
    logic [OUT_W-1:0]    m_tdata;        // slot_index, entry_block, pin_block, zero pad
    logic                m_tlast;        // last

    // Shadow state of the journal
    logic [BLOCK_W-1:0]  tbl_blocks [LOG_ENTRIES];
    int                  tbl_count;
    int                  open_ops;
    bit                  commit_busy;
    int                  log_area;

    journal_result_t     journal_results[$];
    int                  failures;
    int                  cycle_count = 0;
    bit                  send_gaps;
    bit                  recv_stalls;

    write_ahead_log_transaction_tracker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 50 MHz clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Abandon a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic void push_result(status_t status, int slot, logic [BLOCK_W-1:0] blk,
                                        logic pin, logic last);
        journal_result_t r;
        r.status = status;
        r.slot   = slot[SLOT_W-1:0];
        r.blk    = blk;
        r.pin    = pin;
        r.last   = last;
        journal_results.push_back(r);
    endfunction

    // Advance the shadow journal by one request and queue the responses it causes
    function automatic void predict_journal(req_t req, logic [BLOCK_W-1:0] blk);
        int need;
        int hit;
        hit = -1;
        case (req)
            REQ_BEGIN:
            begin
                need = tbl_count + (open_ops + 1) * MAX_OP_BLOCKS;
                if (commit_busy || need > LOG_ENTRIES)
                    push_result(ST_WAIT, 0, '0, 1'b0, 1'b1);
                else
                begin
                    open_ops++;
                    push_result(ST_ADMITTED, 0, '0, 1'b0, 1'b1);
                end
            end
            REQ_END:
            begin
                if (commit_busy)
                    push_result(ST_ERR_END_COMMIT, 0, '0, 1'b0, 1'b1);
                else if (open_ops == 0)
                    push_result(ST_ERR_END_IDLE, 0, '0, 1'b0, 1'b1);
                else
                begin
                    open_ops--;
                    if (open_ops != 0 || tbl_count == 0)
                        push_result(ST_ENDED, 0, '0, 1'b0, 1'b1);
                    else
                    begin
                        commit_busy = 1'b1;
                        for (int i = 0; i < tbl_count; i++)
                            push_result(ST_COMMIT, i, tbl_blocks[i], 1'b0, i + 1 == tbl_count);
                    end
                end
            end
            REQ_WRITE:
            begin
                if (tbl_count >= LOG_ENTRIES || tbl_count + 1 >= log_area)
                    push_result(ST_ERR_FULL, 0, '0, 1'b0, 1'b1);
                else if (open_ops == 0)
                    push_result(ST_ERR_NO_OP, 0, '0, 1'b0, 1'b1);
                else
                begin
                    for (int i = 0; i < tbl_count; i++)
                        if (hit < 0 && tbl_blocks[i] == blk)
                            hit = i;
                    if (hit >= 0)
                        push_result(ST_ABSORBED, hit, blk, 1'b0, 1'b1);
                    else
                    begin
                        tbl_blocks[tbl_count] = blk;
                        push_result(ST_APPENDED, tbl_count, blk, 1'b1, 1'b1);
                        tbl_count++;
                    end
                end
            end
            default:
            begin
                if (!commit_busy)
                    push_result(ST_ERR_DONE_IDLE, 0, '0, 1'b0, 1'b1);
                else
                begin
                    tbl_count   = 0;
                    commit_busy = 1'b0;
                    push_result(ST_CLEARED, 0, '0, 1'b0, 1'b1);
                end
            end
        endcase
    endfunction

    // Present one request and hold it until the front end accepts it
    task automatic send_request(req_t req, logic [BLOCK_W-1:0] blk);
        int gap;
        gap = send_gaps ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= blk;
        do @(posedge clk); while (!s_tready);
        predict_journal(req, blk);
    endtask

    // Hold off the sender until every response is in, then let the back end settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (journal_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_log_area(logic [CFG_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        log_area = value;
    endtask

    // Compare one response against the oldest expectation
    task automatic check_result();
        journal_result_t exp_r;
        if (journal_results.size() == 0)
        begin
            $error("unexpected response: status %0d, m_tdata %h", m_tuser, m_tdata);
            failures++;
        end
        else
        begin
            exp_r = journal_results.pop_front();
            if (m_tuser !== exp_r.status)
            begin
                $error("status mismatch: expected %0d, got %0d", exp_r.status, m_tuser);
                failures++;
            end
            if (m_tdata[SLOT_W-1:0] !== exp_r.slot)
            begin
                $error("slot_index mismatch: expected %0d, got %0d", exp_r.slot,
                       m_tdata[SLOT_W-1:0]);
                failures++;
            end
            if (m_tdata[SLOT_W+BLOCK_W-1:SLOT_W] !== exp_r.blk)
            begin
                $error("entry_block mismatch: expected %h, got %h", exp_r.blk,
                       m_tdata[SLOT_W+BLOCK_W-1:SLOT_W]);
                failures++;
            end
            if (m_tdata[SLOT_W+BLOCK_W] !== exp_r.pin)
            begin
                $error("pin_block mismatch: expected %0d, got %0d", exp_r.pin,
                       m_tdata[SLOT_W+BLOCK_W]);
                failures++;
            end
            if (m_tdata[OUT_W-1:SLOT_W+BLOCK_W+1] !== '0)
            begin
                $error("tdata pad mismatch: expected 0, got %0d",
                       m_tdata[OUT_W-1:SLOT_W+BLOCK_W+1]);
                failures++;
            end
            if (m_tlast !== exp_r.last)
            begin
                $error("last mismatch: expected %0d, got %0d", exp_r.last, m_tlast);
                failures++;
            end
        end
    endtask

    // Accept responses with random back-pressure
    initial
    begin : response_sink
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = recv_stalls ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            check_result();
        end
    end

    // Errors outside an operation and the whole begin/write/end/commit cycle
    task automatic test_idle_errors();
        send_request(REQ_END, '0);
        send_request(REQ_DONE, '0);
        send_request(REQ_WRITE, '0);
    endtask

    task automatic test_group_commit();
        send_request(REQ_BEGIN, '0);
        send_request(REQ_WRITE, 32'h0000_0000);
        send_request(REQ_WRITE, 32'hFFFF_FFFF);
        send_request(REQ_WRITE, 32'hFFFF_FFFF);
        send_request(REQ_WRITE, 32'h0000_0000);
        send_request(REQ_BEGIN, '0);
        send_request(REQ_BEGIN, '0);
        // budget exhausted: expect wait
        send_request(REQ_BEGIN, '0);
        send_request(REQ_WRITE, 32'hA5A5_5A5A);
        send_request(REQ_END, '0);
        send_request(REQ_END, '0);
        send_request(REQ_END, '0);
        // commit in flight
        send_request(REQ_BEGIN, '0);
        send_request(REQ_END, '0);
        send_request(REQ_WRITE, 32'h5A5A_A5A5);
        send_request(REQ_DONE, '0);
        send_request(REQ_DONE, '0);
        // last close with an empty table
        send_request(REQ_BEGIN, '0);
        send_request(REQ_END, '0);
    endtask

    // Smallest log area: one usable entry, full check ahead of the no-operation check
    task automatic test_log_area_limit();
        write_log_area(11'd2);
        send_request(REQ_BEGIN, '0);
        send_request(REQ_WRITE, 32'h1234_5678);
        send_request(REQ_WRITE, 32'h8765_4321);
        send_request(REQ_END, '0);
        send_request(REQ_WRITE, 32'h0000_0001);
        send_request(REQ_DONE, '0);
    endtask

    // Fill every slot, overflow once, then commit the full table
    task automatic test_full_table(logic [CFG_W-1:0] area);
        logic [BLOCK_W-1:0] blk;
        write_log_area(area);
        send_request(REQ_BEGIN, '0);
        for (int i = 0; i < LOG_ENTRIES; i++)
        begin
            blk = {i[4:0], 27'($urandom())};
            send_request(REQ_WRITE, blk);
        end
        send_request(REQ_WRITE, $urandom());
        send_request(REQ_BEGIN, '0);
        send_request(REQ_END, '0);
        send_request(REQ_DONE, '0);
    endtask

    // Mostly well-formed operations with random content, some noise
    task automatic test_random_traffic(int n_items);
        int                 pick;
        req_t               req;
        logic [BLOCK_W-1:0] blk;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 30 == 0)
            begin
                send_gaps   = $urandom_range(0, 2) != 0;
                recv_stalls = $urandom_range(0, 2) != 0;
            end
            if (i % 60 == 59)
            begin
                case ($urandom_range(0, 4))
                    0:       write_log_area(11'd2);
                    1:       write_log_area(11'd1024);
                    2:       write_log_area(11'd1023);
                    default: write_log_area(CFG_W'($urandom_range(3, 40)));
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                req = req_t'($urandom_range(0, 3));
            else if (commit_busy)
                req = REQ_DONE;
            else if (open_ops == 0)
                req = REQ_BEGIN;
            else if (pick < 80)
                req = REQ_WRITE;
            else if (pick < 87)
                req = REQ_BEGIN;
            else
                req = REQ_END;
            case ($urandom_range(0, 3))
                0:       blk = (tbl_count > 0) ? tbl_blocks[$urandom_range(0, tbl_count - 1)]
                                               : $urandom();
                1:       blk = $urandom_range(0, 15);
                default: blk = $urandom();
            endcase
            send_request(req, blk);
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= LOG_AREA_RESET;
        s_tvalid    <= 1'b0;
        s_tuser     <= REQ_BEGIN;
        s_tdata     <= '0;
        failures    = 0;
        tbl_count   = 0;
        open_ops    = 0;
        commit_busy = 1'b0;
        log_area    = LOG_AREA_RESET;
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_errors();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        test_group_commit();
        test_log_area_limit();
        test_full_table(11'd1024);
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        test_full_table(LOG_AREA_RESET);
        test_random_traffic(170);

        drain_results();
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
